### src/nrce_pkg.sv
`timescale 1ns / 1ps

package nrce_pkg;

    localparam int CHAR_W      = 8;
    localparam int POS_W       = 4;
    localparam int LAT_DEG_W   = 7;
    localparam int LON_DEG_W   = 10;
    localparam int MIN_W       = 20;
    localparam int MICRO_W     = 20;
    localparam int RAW_MICRO_W = 21;
    localparam int STATUS_W    = 2;

    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [CHAR_W-1:0] FIX_MARKER_RESET  = 8'd65;
    localparam logic [CHAR_W-1:0] HEMI_MARKER_RESET = 8'd78;

    localparam logic [POS_W-1:0] LAT_LAST       = 4'd8;
    localparam logic [POS_W-1:0] LON_LAST       = 4'd9;
    localparam logic [POS_W-1:0] LAT_POINT      = 4'd4;
    localparam logic [POS_W-1:0] LON_POINT      = 4'd5;
    localparam logic [POS_W-1:0] LAT_DEG_DIGITS = 4'd2;
    localparam logic [POS_W-1:0] LON_DEG_DIGITS = 4'd3;

    // minutes * 5 / 3 as one multiply: 5 * (2^23 + 1) / 3, then drop 23 bits
    localparam int                  RECIP_SHIFT = 23;
    localparam int                  RECIP_W     = 24;
    localparam int                  PROD_W      = MIN_W + RECIP_W;
    localparam logic [RECIP_W-1:0]  RECIP_MUL   = 24'd13981015;

    localparam logic [RAW_MICRO_W-1:0] MICRO_PER_DEG = 21'd1000000;

    localparam logic [STATUS_W-1:0] ST_FIX       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIX    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd2;

    localparam logic [0:0] CFG_FIX_MARKER  = 1'b0;
    localparam logic [0:0] CFG_HEMI_MARKER = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT_FIX,
        PH_LAT,
        PH_HUNT_HEMI,
        PH_LON,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [LAT_DEG_W-1:0] lat_deg;
        logic [MIN_W-1:0]     lat_min;
        logic [LON_DEG_W-1:0] lon_deg;
        logic [MIN_W-1:0]     lon_min;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [LAT_DEG_W-1:0]   lat_deg;
        logic [RAW_MICRO_W-1:0] lat_raw;
        logic [LON_DEG_W-1:0]   lon_deg;
        logic [RAW_MICRO_W-1:0] lon_raw;
    } mid_t;

endpackage

### src/nrce_parser.sv
`timescale 1ns / 1ps

module nrce_parser
    import nrce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] rx_byte,
    input  logic              end_of_response,
    input  logic [CHAR_W-1:0] fix_marker,
    input  logic [CHAR_W-1:0] hemi_marker,
    output logic              req_valid,
    input  logic              req_ready,
    output req_t              req
);

    phase_t                phase_reg, phase_next;
    logic [CHAR_W-1:0]     prev_reg, prev_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [LAT_DEG_W-1:0]  lat_deg_reg, lat_deg_next;
    logic [MIN_W-1:0]      lat_min_reg, lat_min_next;
    logic [LON_DEG_W-1:0]  lon_deg_reg, lon_deg_next;
    logic [MIN_W-1:0]      lon_min_reg, lon_min_next;
    logic                  bad_reg, bad_next;
    logic                  given_reg, given_next;
    logic                  req_valid_reg, req_valid_next;
    req_t                  req_reg, req_next;

    logic                  accept;
    logic                  is_digit;
    logic [3:0]            digit;
    logic                  fire;
    req_t                  result;

    assign in_ready  = !req_valid_reg || req_ready;
    assign accept    = in_valid && in_ready;
    assign req_valid = req_valid_reg;
    assign req       = req_reg;

    assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign digit    = is_digit ? 4'(rx_byte - CHAR_ZERO) : 4'd0;

    always_comb
    begin
        phase_next   = phase_reg;
        prev_next    = prev_reg;
        pos_next     = pos_reg;
        lat_deg_next = lat_deg_reg;
        lat_min_next = lat_min_reg;
        lon_deg_next = lon_deg_reg;
        lon_min_next = lon_min_reg;
        bad_next     = bad_reg;
        given_next   = given_reg;
        fire         = 1'b0;
        result       = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT_FIX:
                begin
                    prev_next = rx_byte;
                    pos_next  = 4'd1;
                    if (pos_reg != '0 && prev_reg == fix_marker && rx_byte == CHAR_COMMA)
                    begin
                        phase_next = PH_LAT;
                        pos_next   = '0;
                    end
                end
                PH_LAT:
                begin
                    if (pos_reg != LAT_POINT)
                    begin
                        if (!is_digit)
                        begin
                            bad_next = 1'b1;
                        end
                        if (pos_reg < LAT_DEG_DIGITS)
                        begin
                            lat_deg_next = LAT_DEG_W'(lat_deg_reg * 7'd10 + LAT_DEG_W'(digit));
                        end
                        else
                        begin
                            lat_min_next = MIN_W'(lat_min_reg * 20'd10 + MIN_W'(digit));
                        end
                    end
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg >= LAT_LAST)
                    begin
                        phase_next = PH_HUNT_HEMI;
                        pos_next   = '0;
                        prev_next  = '0;
                    end
                end
                PH_HUNT_HEMI:
                begin
                    prev_next = rx_byte;
                    pos_next  = 4'd1;
                    if (pos_reg != '0 && prev_reg == hemi_marker && rx_byte == CHAR_COMMA)
                    begin
                        phase_next = PH_LON;
                        pos_next   = '0;
                    end
                end
                PH_LON:
                begin
                    if (pos_reg != LON_POINT)
                    begin
                        if (!is_digit)
                        begin
                            bad_next = 1'b1;
                        end
                        if (pos_reg < LON_DEG_DIGITS)
                        begin
                            lon_deg_next = LON_DEG_W'(lon_deg_reg * 10'd10 + LON_DEG_W'(digit));
                        end
                        else
                        begin
                            lon_min_next = MIN_W'(lon_min_reg * 20'd10 + MIN_W'(digit));
                        end
                    end
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg >= LON_LAST)
                    begin
                        phase_next = PH_DONE;
                        pos_next   = '0;
                        given_next = 1'b1;
                        fire       = 1'b1;
                        if (bad_next)
                        begin
                            result.status = ST_MALFORMED;
                        end
                        else
                        begin
                            result.status  = ST_FIX;
                            result.lat_deg = lat_deg_next;
                            result.lat_min = lat_min_next;
                            result.lon_deg = lon_deg_next;
                            result.lon_min = lon_min_next;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (end_of_response)
            begin
                if (!given_next)
                begin
                    fire          = 1'b1;
                    result        = '0;
                    result.status = ST_NO_FIX;
                end
                phase_next   = PH_HUNT_FIX;
                prev_next    = '0;
                pos_next     = '0;
                lat_deg_next = '0;
                lat_min_next = '0;
                lon_deg_next = '0;
                lon_min_next = '0;
                bad_next     = 1'b0;
                given_next   = 1'b0;
            end
        end
    end

    always_comb
    begin
        req_valid_next = req_valid_reg;
        req_next       = req_reg;
        if (in_ready)
        begin
            req_valid_next = fire;
            req_next       = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT_FIX;
            prev_reg      <= '0;
            pos_reg       <= '0;
            lat_deg_reg   <= '0;
            lat_min_reg   <= '0;
            lon_deg_reg   <= '0;
            lon_min_reg   <= '0;
            bad_reg       <= 1'b0;
            given_reg     <= 1'b0;
            req_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            prev_reg      <= prev_next;
            pos_reg       <= pos_next;
            lat_deg_reg   <= lat_deg_next;
            lat_min_reg   <= lat_min_next;
            lon_deg_reg   <= lon_deg_next;
            lon_min_reg   <= lon_min_next;
            bad_reg       <= bad_next;
            given_reg     <= given_next;
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

endmodule

### src/nrce_convert.sv
`timescale 1ns / 1ps

module nrce_convert
    import nrce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [LAT_DEG_W-1:0] lat_degrees,
    output logic [MICRO_W-1:0]   lat_micro,
    output logic [LON_DEG_W-1:0] lon_degrees,
    output logic [MICRO_W-1:0]   lon_micro
);

    logic                  mid_valid_reg, mid_valid_next;
    mid_t                  mid_reg, mid_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [LAT_DEG_W-1:0]  lat_deg_reg, lat_deg_next;
    logic [MICRO_W-1:0]    lat_micro_reg, lat_micro_next;
    logic [LON_DEG_W-1:0]  lon_deg_reg, lon_deg_next;
    logic [MICRO_W-1:0]    lon_micro_reg, lon_micro_next;

    logic                  out_load;
    logic                  mid_load;
    logic [PROD_W-1:0]     lat_prod;
    logic [PROD_W-1:0]     lon_prod;
    logic                  lat_carry;
    logic                  lon_carry;

    assign out_load  = !out_valid_reg || out_ready;
    assign mid_load  = !mid_valid_reg || out_load;
    assign req_ready = mid_load;

    // minutes to micro-degrees
    assign lat_prod = PROD_W'(req.lat_min) * PROD_W'(RECIP_MUL);
    assign lon_prod = PROD_W'(req.lon_min) * PROD_W'(RECIP_MUL);

    always_comb
    begin
        mid_valid_next = mid_valid_reg;
        mid_next       = mid_reg;
        if (mid_load)
        begin
            mid_valid_next   = req_valid;
            mid_next.status  = req.status;
            mid_next.lat_deg = req.lat_deg;
            mid_next.lat_raw = lat_prod[RECIP_SHIFT +: RAW_MICRO_W];
            mid_next.lon_deg = req.lon_deg;
            mid_next.lon_raw = lon_prod[RECIP_SHIFT +: RAW_MICRO_W];
        end
    end

    // carry whole degrees out of the micro-degree part
    assign lat_carry = mid_reg.lat_raw >= MICRO_PER_DEG;
    assign lon_carry = mid_reg.lon_raw >= MICRO_PER_DEG;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        lat_deg_next   = lat_deg_reg;
        lat_micro_next = lat_micro_reg;
        lon_deg_next   = lon_deg_reg;
        lon_micro_next = lon_micro_reg;
        if (out_load)
        begin
            out_valid_next = mid_valid_reg;
            status_next    = mid_reg.status;
            lat_deg_next   = mid_reg.lat_deg + LAT_DEG_W'(lat_carry);
            lon_deg_next   = mid_reg.lon_deg + LON_DEG_W'(lon_carry);
            lat_micro_next = lat_carry ? MICRO_W'(mid_reg.lat_raw - MICRO_PER_DEG)
                                       : MICRO_W'(mid_reg.lat_raw);
            lon_micro_next = lon_carry ? MICRO_W'(mid_reg.lon_raw - MICRO_PER_DEG)
                                       : MICRO_W'(mid_reg.lon_raw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg       <= mid_next;
        status_reg    <= status_next;
        lat_deg_reg   <= lat_deg_next;
        lat_micro_reg <= lat_micro_next;
        lon_deg_reg   <= lon_deg_next;
        lon_micro_reg <= lon_micro_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign lat_degrees = lat_deg_reg;
    assign lat_micro   = lat_micro_reg;
    assign lon_degrees = lon_deg_reg;
    assign lon_micro   = lon_micro_reg;

endmodule

### src/nmea_rmc_coordinate_extractor.sv
`timescale 1ns / 1ps
// a result request passes the parser's request register, the middle register and the output registers
// throughput: one byte per cycle while in_ready is high; the parse state updates in the cycle a byte is taken
// conversion runs in two registered stages (one multiply, then a compare and subtract)
// reset: asynchronous, active low; parse state clears, markers return to 'A' and 'N'
// a byte with the end mark also returns the parse state to its reset value
module nmea_rmc_coordinate_extractor
    import nrce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [0:0]           cfg_index,
    input  logic [CHAR_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CHAR_W-1:0]    rx_byte,
    input  logic                 end_of_response,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [LAT_DEG_W-1:0] lat_degrees,
    output logic [MICRO_W-1:0]   lat_micro,
    output logic [LON_DEG_W-1:0] lon_degrees,
    output logic [MICRO_W-1:0]   lon_micro
);

    logic [CHAR_W-1:0] fix_marker_reg, fix_marker_next;
    logic [CHAR_W-1:0] hemi_marker_reg, hemi_marker_next;
    logic              req_valid;
    logic              req_ready;
    req_t              req;

    always_comb
    begin
        fix_marker_next  = fix_marker_reg;
        hemi_marker_next = hemi_marker_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FIX_MARKER:  fix_marker_next  = cfg_data;
                CFG_HEMI_MARKER: hemi_marker_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix_marker_reg  <= FIX_MARKER_RESET;
            hemi_marker_reg <= HEMI_MARKER_RESET;
        end
        else
        begin
            fix_marker_reg  <= fix_marker_next;
            hemi_marker_reg <= hemi_marker_next;
        end
    end

    nrce_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .end_of_response (end_of_response),
        .fix_marker      (fix_marker_reg),
        .hemi_marker     (hemi_marker_reg),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req             (req)
    );

    nrce_convert u_convert (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .lat_degrees (lat_degrees),
        .lat_micro   (lat_micro),
        .lon_degrees (lon_degrees),
        .lon_micro   (lon_micro)
    );

endmodule

### sim/nmea_rmc_coordinate_extractor_test.sv
`timescale 1ns / 1ps

module nmea_rmc_coordinate_extractor_test;
    import nrce_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 200;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_BYTES    = 70;

    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic [LAT_DEG_W-1:0] lat_degrees;
        logic [MICRO_W-1:0]   lat_micro;
        logic [LON_DEG_W-1:0] lon_degrees;
        logic [MICRO_W-1:0]   lon_micro;
    } fix_report_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [0:0]           cfg_index;
    logic [CHAR_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [CHAR_W-1:0]    rx_byte;
    logic                 end_of_response;
    logic                 out_valid;
    logic                 out_ready;
    logic [STATUS_W-1:0]  status;
    logic [LAT_DEG_W-1:0] lat_degrees;
    logic [MICRO_W-1:0]   lat_micro;
    logic [LON_DEG_W-1:0] lon_degrees;
    logic [MICRO_W-1:0]   lon_micro;

    // predictor copy of the parser
    logic [CHAR_W-1:0]    fix_marker;
    logic [CHAR_W-1:0]    hemi_marker;
    phase_t               parse_state;
    logic [CHAR_W-1:0]    prev_char;
    logic [POS_W-1:0]     field_pos;
    logic [LAT_DEG_W-1:0] lat_deg_acc;
    logic [MIN_W-1:0]     lat_min_acc;
    logic [LON_DEG_W-1:0] lon_deg_acc;
    logic [MIN_W-1:0]     lon_min_acc;
    logic                 malformed;
    logic                 fix_given;

    fix_report_t          pending_fixes[$];
    logic [CHAR_W-1:0]    frame_q[$];

    int                   error_count;
    int                   idle_cycles;
    int unsigned          bytes_sent;
    logic                 idle_on;
    logic                 hold_req;

    nmea_rmc_coordinate_extractor u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .end_of_response (end_of_response),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .lat_degrees     (lat_degrees),
        .lat_micro       (lat_micro),
        .lon_degrees     (lon_degrees),
        .lon_micro       (lon_micro)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_error(input string msg);
        $display("ERROR: %s at %0t", msg, $time);
        error_count++;
    endtask

    task automatic restart_parse();
        parse_state = PH_HUNT_FIX;
        prev_char   = '0;
        field_pos   = '0;
        lat_deg_acc = '0;
        lat_min_acc = '0;
        lon_deg_acc = '0;
        lon_min_acc = '0;
        malformed   = 1'b0;
        fix_given   = 1'b0;
    endtask

    function automatic void split_micro(input logic [MIN_W-1:0] min_e4,
                                        output int unsigned whole,
                                        output int unsigned frac);
        int unsigned micro;
        micro = (32'(min_e4) * 32'd5) / 32'd3;
        whole = micro / 32'(MICRO_PER_DEG);
        frac  = micro % 32'(MICRO_PER_DEG);
    endfunction

    task automatic parse_byte(input logic [CHAR_W-1:0] c, input logic last);
        logic [CHAR_W-1:0] marker;
        logic              is_digit;
        logic [3:0]        digit;
        logic              produced;
        fix_report_t       rep;
        int unsigned       whole;
        int unsigned       frac;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        digit    = is_digit ? 4'(c - CHAR_ZERO) : 4'd0;
        produced = 1'b0;
        rep      = '{default: '0};
        case (parse_state)
            PH_HUNT_FIX, PH_HUNT_HEMI:
            begin
                marker = (parse_state == PH_HUNT_FIX) ? fix_marker : hemi_marker;
                if (field_pos != 0 && prev_char == marker && c == CHAR_COMMA)
                begin
                    if (parse_state == PH_HUNT_FIX)
                        parse_state = PH_LAT;
                    else
                        parse_state = PH_LON;
                    field_pos = '0;
                end
                else
                begin
                    field_pos = POS_W'(1);
                end
                prev_char = c;
            end
            PH_LAT:
            begin
                if (field_pos != LAT_POINT)
                begin
                    if (!is_digit)
                        malformed = 1'b1;
                    if (field_pos < LAT_DEG_DIGITS)
                        lat_deg_acc = LAT_DEG_W'(lat_deg_acc * 10 + digit);
                    else
                        lat_min_acc = MIN_W'(lat_min_acc * 10 + digit);
                end
                field_pos = field_pos + 1'b1;
                if (field_pos > LAT_LAST)
                begin
                    parse_state = PH_HUNT_HEMI;
                    field_pos   = '0;
                    prev_char   = '0;
                end
            end
            PH_LON:
            begin
                if (field_pos != LON_POINT)
                begin
                    if (!is_digit)
                        malformed = 1'b1;
                    if (field_pos < LON_DEG_DIGITS)
                        lon_deg_acc = LON_DEG_W'(lon_deg_acc * 10 + digit);
                    else
                        lon_min_acc = MIN_W'(lon_min_acc * 10 + digit);
                end
                field_pos = field_pos + 1'b1;
                if (field_pos > LON_LAST)
                begin
                    parse_state = PH_DONE;
                    field_pos   = '0;
                    fix_given   = 1'b1;
                    produced    = 1'b1;
                    if (malformed)
                    begin
                        rep.status = ST_MALFORMED;
                    end
                    else
                    begin
                        rep.status = ST_FIX;
                        split_micro(lat_min_acc, whole, frac);
                        rep.lat_degrees = LAT_DEG_W'(32'(lat_deg_acc) + whole);
                        rep.lat_micro   = MICRO_W'(frac);
                        split_micro(lon_min_acc, whole, frac);
                        rep.lon_degrees = LON_DEG_W'(32'(lon_deg_acc) + whole);
                        rep.lon_micro   = MICRO_W'(frac);
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (last && !fix_given)
        begin
            rep        = '{default: '0};
            rep.status = ST_NO_FIX;
            produced   = 1'b1;
        end
        if (produced)
            pending_fixes.push_back(rep);
        if (last)
            restart_parse();
    endtask

    task automatic send_byte(input logic [CHAR_W-1:0] value, input logic last);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_byte         = value;
        end_of_response = last;
        in_valid        = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        parse_byte(value, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
    endtask

    task automatic add_text(input string text);
        int i;
        for (i = 0; i < text.len(); i++)
            frame_q.push_back(text[i]);
    endtask

    task automatic add_noise(input int unsigned count);
        repeat (count) frame_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_field(input int unsigned len, input int unsigned point, input bit bad);
        int unsigned i;
        int unsigned start;
        int unsigned fill;
        int unsigned j;
        start = frame_q.size();
        fill  = $urandom_range(0, 9);
        for (i = 0; i < len; i++)
        begin
            if (i == point)
                frame_q.push_back(($urandom_range(0, 3) == 0) ?
                                  8'($urandom_range(0, 255)) : CHAR_POINT);
            else if (fill == 0)
                frame_q.push_back(CHAR_ZERO);
            else if (fill == 1)
                frame_q.push_back(CHAR_NINE);
            else
                frame_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        if (bad)
        begin
            j = $urandom_range(0, len - 2);
            if (j >= point)
                j++;
            frame_q[start + j] = 8'($urandom_range(0, 255));
        end
    endtask

    task automatic wait_drain();
        in_valid = 1'b0;
        while (pending_fixes.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_marker(input logic [0:0] index, input logic [CHAR_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        if (index == CFG_FIX_MARKER)
            fix_marker = value;
        else
            hemi_marker = value;
    endtask

    task automatic send_random_response();
        int unsigned pick;
        int unsigned cut;
        pick    = $urandom_range(0, 99);
        idle_on = ($urandom_range(0, 3) != 0);
        if (pick < 70)
        begin
            add_noise($urandom_range(0, 4));
            frame_q.push_back(fix_marker);
            frame_q.push_back(CHAR_COMMA);
            add_field(9, LAT_POINT, $urandom_range(0, 9) == 0);
            add_noise($urandom_range(0, 3));
            frame_q.push_back(hemi_marker);
            frame_q.push_back(CHAR_COMMA);
            add_field(10, LON_POINT, $urandom_range(0, 9) == 0);
            add_noise($urandom_range(0, 3));
            if ($urandom_range(0, 6) == 0)
            begin
                cut = $urandom_range(1, frame_q.size());
                while (frame_q.size() > cut)
                    void'(frame_q.pop_back());
            end
        end
        else if (pick < 85)
        begin
            add_noise($urandom_range(1, 12));
        end
        else
        begin
            repeat ($urandom_range(1, 30))
            begin
                case ($urandom_range(0, 4))
                    0: frame_q.push_back(fix_marker);
                    1: frame_q.push_back(hemi_marker);
                    2: frame_q.push_back(CHAR_COMMA);
                    3: frame_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                    default: frame_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        send_frame();
    endtask

    task automatic test_fix_extremes();
        add_text("A,9999.9999N,99999.9999");
        send_frame();
        add_text("xA,0000!0000,N,00000?0000,E");
        send_frame();
        add_text("A,4530.1234N,12259.8765");
        send_frame();
    endtask

    task automatic test_malformed_digits();
        add_text("A,0/00.0000N,00000.0000");
        send_frame();
        add_text("A,0000.0000N,000:0.0000");
        send_frame();
    endtask

    task automatic test_no_fix();
        add_text("A");
        send_frame();
        // marker pair must not straddle the end of the latitude field
        add_text("A,1234.567N,");
        send_frame();
        // nor a response boundary
        add_text("B,A");
        send_frame();
        add_text(",1234.5678");
        send_frame();
        wait_drain();
    endtask

    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (40)
        begin
            add_noise(1);
            send_frame();
        end
        wait_drain();
        idle_on = 1'b1;
    endtask

    task automatic test_marker_settings();
        int                k;
        int unsigned       goal;
        logic [CHAR_W-1:0] f;
        logic [CHAR_W-1:0] h;
        for (k = 0; k < 5; k++)
        begin
            case (k)
                0:
                begin
                    f = 8'h00;
                    h = 8'hFF;
                end
                1:
                begin
                    f = 8'hFF;
                    h = 8'h00;
                end
                2:
                begin
                    f = CHAR_COMMA;
                    h = CHAR_COMMA;
                end
                3:
                begin
                    f = 8'($urandom_range(0, 255));
                    h = 8'($urandom_range(0, 255));
                end
                default:
                begin
                    f = FIX_MARKER_RESET;
                    h = HEMI_MARKER_RESET;
                end
            endcase
            wait_drain();
            write_marker(CFG_FIX_MARKER, f);
            write_marker(CFG_HEMI_MARKER, h);
            goal = bytes_sent + PHASE_BYTES;
            while (bytes_sent < goal)
                send_random_response();
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        int unsigned stall;
        out_ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                stall = idle_on ? $urandom_range(0, 4) : 0;
                if (stall != 0)
                begin
                    out_ready = 1'b0;
                    repeat (stall) @(negedge clk);
                end
                out_ready = 1'b1;
                @(posedge clk);
                while (!out_valid && !hold_req) @(posedge clk);
                @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        fix_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_fixes.size() == 0)
            begin
                report_error($sformatf("result with nothing expected, status %0d", status));
            end
            else
            begin
                want = pending_fixes.pop_front();
                if (status !== want.status)
                    report_error($sformatf("status %0d expected %0d", status, want.status));
                if (lat_degrees !== want.lat_degrees)
                    report_error($sformatf("lat_degrees %0d expected %0d",
                                           lat_degrees, want.lat_degrees));
                if (lat_micro !== want.lat_micro)
                    report_error($sformatf("lat_micro %0d expected %0d",
                                           lat_micro, want.lat_micro));
                if (lon_degrees !== want.lon_degrees)
                    report_error($sformatf("lon_degrees %0d expected %0d",
                                           lon_degrees, want.lon_degrees));
                if (lon_micro !== want.lon_micro)
                    report_error($sformatf("lon_micro %0d expected %0d",
                                           lon_micro, want.lon_micro));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        rx_byte         = '0;
        end_of_response = 1'b0;
        idle_on         = 1'b1;
        hold_req        = 1'b0;
        error_count     = 0;
        idle_cycles     = 0;
        bytes_sent      = 0;
        fix_marker      = FIX_MARKER_RESET;
        hemi_marker     = HEMI_MARKER_RESET;
        restart_parse();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_fix_extremes();
        test_malformed_digits();
        test_no_fix();
        test_backpressure();
        test_marker_settings();
        wait_drain();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
src/nrce_pkg.sv
src/nrce_parser.sv
src/nrce_convert.sv
src/nmea_rmc_coordinate_extractor.sv
sim/nmea_rmc_coordinate_extractor_test.sv
